// File: hdl/tga_pixel_stream_decoder_assert.svh
// Assertion macros used by the decoder controller (tpsd_ctrl).
`ifndef TGA_PIXEL_STREAM_DECODER_ASSERT_SVH
`define TGA_PIXEL_STREAM_DECODER_ASSERT_SVH

// Property that must hold at every clock edge outside reset.
`define TPSD_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Implication checked in the next cycle.
`define TPSD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: hdl/tpsd_pkg.sv
// ----------------------------------------------------------------------------
// tpsd_pkg
// Shared types and constants of the TGA pixel stream decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package tpsd_pkg;

   localparam int PALETTE_DEPTH_DEF = 256;

   localparam logic [1:0] REQ_START    = 2'd0;
   localparam logic [1:0] REQ_DATA     = 2'd1;
   localparam logic [1:0] REQ_PALETTE  = 2'd2;
   localparam logic [1:0] REQ_RESERVED = 2'd3;

   localparam logic [2:0] CSR_WIDTH   = 3'd0;
   localparam logic [2:0] CSR_HEIGHT  = 3'd1;
   localparam logic [2:0] CSR_FORMAT  = 3'd2;
   localparam logic [2:0] CSR_PALETTE = 3'd3;
   localparam logic [2:0] CSR_RLE     = 3'd4;
   localparam logic [2:0] CSR_FLIP    = 3'd5;

   localparam logic [1:0] FMT_GREY     = 2'd0;
   localparam logic [1:0] FMT_BGR      = 2'd1;
   localparam logic [1:0] FMT_BGRA     = 2'd2;
   localparam logic [1:0] FMT_ALT_BGRA = 2'd3;

   localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;
   localparam logic [7:0] COUNT_MASK   = 8'h7F;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_EMIT
   } state_type;

   // Controller to datapath commands.
   typedef struct packed {
      logic take_byte;   // accept a data byte into the datapath
      logic pal_write;   // write the palette
      logic start;       // clear stream state
      logic emit_span;   // one span was accepted on the output
      logic look_done;   // palette read data ready, latch color
   } cmd_type;

   // Datapath to controller status.
   typedef struct packed {
      logic pixel_ready; // a pixel (or overflow) is waiting to go out
      logic need_lookup; // the pending pixel needs a palette read
      logic more_spans;  // spans remain after the current one
   } status_type;

endpackage

`default_nettype wire

// File: hdl/tpsd_ram.sv
// ----------------------------------------------------------------------------
// tpsd_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module tpsd_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

// File: hdl/tpsd_ctrl.sv
// ----------------------------------------------------------------------------
// tpsd_ctrl
// Controller: sequences byte intake, palette lookup and span emission.
// ----------------------------------------------------------------------------
`default_nettype none

module tpsd_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_tvalid,
   output logic                      req_tready,
   input  wire logic [1:0]           req_kind,
   output logic                      rsp_tvalid,
   input  wire logic                 rsp_tready,
   input  wire tpsd_pkg::status_type status,
   output tpsd_pkg::cmd_type         cmd
);
   import tpsd_pkg::*;

   state_type state_ff, state_in;
   logic      acc;
   logic      fire;

   assign acc  = req_tvalid && req_tready;
   assign fire = rsp_tvalid && rsp_tready;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (status.pixel_ready) begin
               state_in = status.need_lookup ? ST_LOOKUP : ST_EMIT;
            end
         end
         ST_LOOKUP: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (fire && !status.more_spans) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Outputs
   always_comb begin
      req_tready     = 1'b0;
      rsp_tvalid     = 1'b0;
      cmd            = '0;
      case (state_ff)
         ST_IDLE: begin
            req_tready    = !status.pixel_ready;
            cmd.take_byte = acc && (req_kind == REQ_DATA);
            cmd.pal_write = acc && (req_kind == REQ_PALETTE);
            cmd.start     = acc && (req_kind == REQ_START);
         end
         ST_LOOKUP: begin
            cmd.look_done = 1'b1;
         end
         ST_EMIT: begin
            rsp_tvalid    = 1'b1;
            cmd.emit_span = fire;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

`include "tga_pixel_stream_decoder_assert.svh"

   `TPSD_ASSERT(a_no_overlap, clock, reset, !(req_tready && rsp_tvalid), "input and output overlap")
   `TPSD_ASSERT_NEXT(a_lookup_emit, clock, reset, state_ff == ST_LOOKUP, state_ff == ST_EMIT, "lookup must lead to emit")
   `TPSD_ASSERT_NEXT(a_hold_emit, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid, "span withdrawn")

endmodule

`default_nettype wire

// File: hdl/tpsd_datapath.sv
// ----------------------------------------------------------------------------
// tpsd_datapath
// Datapath: pixel assembly, RLE packet state, palette RAM, span generation.
// ----------------------------------------------------------------------------
`default_nettype none

module tpsd_datapath #(
   parameter int PALETTE_DEPTH = tpsd_pkg::PALETTE_DEPTH_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire tpsd_pkg::cmd_type cmd,
   output tpsd_pkg::status_type   status,
   input  wire logic [7:0]        data_byte,
   input  wire logic [7:0]        palette_index,
   input  wire logic [23:0]       palette_color,
   input  wire logic [15:0]       image_width,
   input  wire logic [15:0]       image_height,
   input  wire logic [1:0]        pixel_format,
   input  wire logic              use_palette,
   input  wire logic              rle_mode,
   input  wire logic              bottom_up,
   output logic [7:0]             red,
   output logic [7:0]             green,
   output logic [7:0]             blue,
   output logic [7:0]             alpha,
   output logic [15:0]            out_row,
   output logic [15:0]            out_col,
   output logic [7:0]             span_len,
   output logic                   last,
   output logic                   frame_done,
   output logic                   overflow_error
);
   import tpsd_pkg::*;

   localparam int AW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;

   // Stream state
   logic [31:0] pixel_count_ff, pixel_count_in;
   logic [15:0] cur_row_ff, cur_row_in;
   logic [15:0] cur_col_ff, cur_col_in;
   logic [7:0]  packet_left_ff, packet_left_in;
   logic        packet_is_run_ff, packet_is_run_in;
   logic [1:0]  byte_phase_ff, byte_phase_in;
   logic [23:0] partial_ff, partial_in;
   logic        halted_ff, halted_in;
   // Palette valid bits (reset clears the valid bits, not the RAM entries)
   logic [PALETTE_DEPTH-1:0] pal_valid_ff, pal_valid_in;
   // Pending pixel
   logic        pend_ff, pend_in;
   logic        pend_look_ff, pend_look_in;
   logic        pend_ovf_ff, pend_ovf_in;
   logic [23:0] pend_color_ff, pend_color_in;
   logic [7:0]  pend_alpha_ff, pend_alpha_in;
   logic [7:0]  pend_count_ff, pend_count_in;   // count minus one
   logic [AW-1:0] look_idx_ff, look_idx_in;
   logic        look_ok_ff, look_ok_in;

   logic [23:0] ram_rd;
   logic [15:0] w_eff, h_eff;
   logic [16:0] room;
   logic [8:0]  cnt;
   logic [8:0]  len;
   logic [16:0] col_end;
   logic [31:0] total_lo;
   logic [32:0] need_total;
   logic        pal_hit;

   tpsd_ram #(.WIDTH(24), .DEPTH(PALETTE_DEPTH)) u_pal (
      .clock   (clock),
      .wr_en   (cmd.pal_write && ({8'd0, palette_index} < 16'(PALETTE_DEPTH))),
      .wr_addr (palette_index[AW-1:0]),
      .wr_data (palette_color),
      .rd_addr (look_idx_ff),
      .rd_data (ram_rd)
   );

   assign w_eff = (image_width < 16'd4) ? 16'd4 : image_width;
   assign h_eff = (image_height == 16'd0) ? 16'd1 : image_height;
   assign total_lo = {16'd0, w_eff} * {16'd0, h_eff};

   // Span geometry for current pending pixel
   assign cnt     = {1'b0, pend_count_ff} + 9'd1;
   assign room    = {1'b0, w_eff} - {1'b0, cur_col_ff};
   assign len     = ({8'd0, cnt} < room) ? cnt : room[8:0];
   assign col_end = {1'b0, cur_col_ff} + {8'd0, len};

   assign pal_hit = pal_valid_ff[look_idx_ff];

   // Outputs straight from pending registers
   assign red            = pend_ovf_ff ? 8'd0 : pend_color_ff[23:16];
   assign green          = pend_ovf_ff ? 8'd0 : pend_color_ff[15:8];
   assign blue           = pend_ovf_ff ? 8'd0 : pend_color_ff[7:0];
   assign alpha          = pend_ovf_ff ? 8'd0 : pend_alpha_ff;
   assign out_row        = pend_ovf_ff ? 16'd0 :
                           (bottom_up ? (h_eff - 16'd1 - cur_row_ff) : cur_row_ff);
   assign out_col        = pend_ovf_ff ? 16'd0 : cur_col_ff;
   assign span_len       = pend_ovf_ff ? 8'd0 : len[7:0];
   assign frame_done     = !pend_ovf_ff && (cur_row_ff == h_eff - 16'd1)
                           && (col_end == {1'b0, w_eff});
   assign last           = pend_ovf_ff || !status.more_spans;
   assign overflow_error = pend_ovf_ff;

   always_comb begin
      status.pixel_ready = pend_ff;
      status.need_lookup = pend_look_ff;
      status.more_spans  = !pend_ovf_ff && (cnt > len)
                           && !(cur_row_ff == h_eff - 16'd1 && col_end == {1'b0, w_eff});
   end

   // Next-state logic
   always_comb begin
      logic [1:0] need;
      logic [7:0] b;
      logic       done;
      logic [1:0] ph;
      need = 2'd0;
      b    = data_byte;
      done = 1'b0;
      ph   = byte_phase_ff;
      pixel_count_in   = pixel_count_ff;
      cur_row_in       = cur_row_ff;
      cur_col_in       = cur_col_ff;
      packet_left_in   = packet_left_ff;
      packet_is_run_in = packet_is_run_ff;
      byte_phase_in    = byte_phase_ff;
      partial_in       = partial_ff;
      halted_in        = halted_ff;
      pal_valid_in     = pal_valid_ff;
      pend_in          = pend_ff;
      pend_look_in     = pend_look_ff;
      pend_ovf_in      = pend_ovf_ff;
      pend_color_in    = pend_color_ff;
      pend_alpha_in    = pend_alpha_ff;
      pend_count_in    = pend_count_ff;
      look_idx_in      = look_idx_ff;
      look_ok_in       = look_ok_ff;
      need_total       = '0;

      if (cmd.start) begin
         pixel_count_in = '0; cur_row_in = '0; cur_col_in = '0;
         packet_left_in = '0; packet_is_run_in = 1'b0; byte_phase_in = '0;
         partial_in = '0; halted_in = 1'b0;
      end

      if (cmd.pal_write && ({8'd0, palette_index} < 16'(PALETTE_DEPTH))) begin
         pal_valid_in[palette_index[AW-1:0]] = 1'b1;
      end

      if (cmd.take_byte && !halted_ff && (cur_row_ff < h_eff)) begin
         if (rle_mode && packet_left_ff == 8'd0) begin
            need_total = {1'b0, pixel_count_ff} + {25'd0, (b & COUNT_MASK)} + 33'd1;
            if (need_total > {1'b0, total_lo}) begin
               halted_in   = 1'b1;
               pend_in     = 1'b1;
               pend_ovf_in = 1'b1;
               pend_look_in = 1'b0;
            end else begin
               pixel_count_in   = need_total[31:0];
               packet_left_in   = (b & COUNT_MASK) + 8'd1;
               packet_is_run_in = b[7];
               byte_phase_in    = '0;
               partial_in       = '0;
            end
         end else begin
            // Pixel byte
            case (pixel_format)
               FMT_GREY: need = 2'd0;
               FMT_BGR:  need = 2'd2;
               default:  need = 2'd3;
            endcase
            pend_alpha_in = ALPHA_OPAQUE;
            if (need == 2'd0) begin
               done = 1'b1;
               byte_phase_in = '0;
               pend_color_in = {b, b, b};
               look_idx_in   = b[AW-1:0];
               look_ok_in    = ({8'd0, b} < 16'(PALETTE_DEPTH));
               pend_look_in  = use_palette;
            end else begin
               pend_look_in = 1'b0;
               if (ph != 2'd3) begin
                  case (ph)
                     2'd0:    partial_in = partial_ff | {16'd0, b};
                     2'd1:    partial_in = partial_ff | {8'd0, b, 8'd0};
                     default: partial_in = partial_ff | {b, 16'd0};
                  endcase
               end else begin
                  pend_alpha_in = b;
               end
               byte_phase_in = ph + 2'd1;
               if (ph >= need) begin
                  done = 1'b1;
                  pend_color_in = partial_in;
                  if (need == 2'd2) pend_alpha_in = ALPHA_OPAQUE;
                  partial_in    = '0;
                  byte_phase_in = '0;
               end
            end
            if (done) begin
               pend_in     = 1'b1;
               pend_ovf_in = 1'b0;
               if (!rle_mode) begin
                  pixel_count_in = pixel_count_ff + 32'd1;
                  pend_count_in  = 8'd0;
               end else if (packet_is_run_ff) begin
                  pend_count_in  = packet_left_ff - 8'd1;
                  packet_left_in = 8'd0;
               end else begin
                  pend_count_in  = 8'd0;
                  packet_left_in = packet_left_ff - 8'd1;
               end
               // Position past the row end wraps before emit.
               if (cur_col_ff >= w_eff) begin
                  cur_col_in = '0;
                  cur_row_in = cur_row_ff + 16'd1;
                  // Pixels that land beyond the last row are dropped.
                  if (cur_row_ff + 16'd1 >= h_eff) begin
                     pend_in      = 1'b0;
                     pend_look_in = 1'b0;
                  end
               end
            end
         end
      end

      if (cmd.look_done) begin
         pend_color_in = (look_ok_ff && pal_hit) ? ram_rd : 24'd0;
         pend_look_in  = 1'b0;
      end

      if (cmd.emit_span) begin
         if (pend_ovf_ff) begin
            pend_in = 1'b0;
         end else begin
            pend_count_in = pend_count_ff - len[7:0];
            if (col_end >= {1'b0, w_eff}) begin
               cur_col_in = '0;
               cur_row_in = cur_row_ff + 16'd1;
            end else begin
               cur_col_in = col_end[15:0];
            end
            if (!status.more_spans) pend_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pixel_count_ff   <= '0;
         cur_row_ff       <= '0;
         cur_col_ff       <= '0;
         packet_left_ff   <= '0;
         packet_is_run_ff <= 1'b0;
         byte_phase_ff    <= '0;
         partial_ff       <= '0;
         halted_ff        <= 1'b0;
         pal_valid_ff     <= '0;
         pend_ff          <= 1'b0;
         pend_look_ff     <= 1'b0;
         pend_ovf_ff      <= 1'b0;
      end else begin
         pixel_count_ff   <= pixel_count_in;
         cur_row_ff       <= cur_row_in;
         cur_col_ff       <= cur_col_in;
         packet_left_ff   <= packet_left_in;
         packet_is_run_ff <= packet_is_run_in;
         byte_phase_ff    <= byte_phase_in;
         partial_ff       <= partial_in;
         halted_ff        <= halted_in;
         pal_valid_ff     <= pal_valid_in;
         pend_ff          <= pend_in;
         pend_look_ff     <= pend_look_in;
         pend_ovf_ff      <= pend_ovf_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_color_ff <= pend_color_in;
      pend_alpha_ff <= pend_alpha_in;
      pend_count_ff <= pend_count_in;
      look_idx_ff   <= look_idx_in;
      look_ok_ff    <= look_ok_in;
   end

endmodule

`default_nettype wire

// File: hdl/tga_pixel_stream_decoder.sv
// ----------------------------------------------------------------------------
// tga_pixel_stream_decoder
// Decodes TGA pixel bytes (raw or RLE) into row-limited BGRA spans.
// ----------------------------------------------------------------------------
//  channel   direction  transaction
//  req_      in         one byte, start, or palette write
//  rsp_      out        one span of identical pixels
//  csr_      in         register write, no handshake
//
//  A byte that completes no pixel leaves input ready. A pixel (or an overflow)
//  goes through intake, dispatch, a palette read when indexed, then its
//  spans, each held until accepted; input is ready again the cycle after
//  the last span. A run is cut at each row end. Input is stalled while
//  spans are pending. Reset is synchronous and clears all stream state and
//  the palette valid bits at once.
`default_nettype none

module tga_pixel_stream_decoder #(
   parameter int PALETTE_DEPTH = tpsd_pkg::PALETTE_DEPTH_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // data_byte[7:0], palette_index[15:8], palette_color[39:16]
   input  wire logic [39:0] req_tdata,
   // req_type[1:0]
   input  wire logic [1:0]  req_tuser,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // red[7:0] green[15:8] blue[23:16] alpha[31:24] out_row[47:32]
   // out_col[63:48] span_len[71:64]
   output logic [71:0]      rsp_tdata,
   output logic             rsp_tlast,
   // frame_done[0], overflow_error[1]
   output logic [1:0]       rsp_tuser,
   input  wire logic        csr_we,
   input  wire logic [2:0]  csr_index,
   input  wire logic [15:0] csr_wdata
);
   import tpsd_pkg::*;

   logic [15:0] width_ff, height_ff;
   logic [1:0]  format_ff;
   logic        pal_ff, rle_ff, flip_ff;
   cmd_type     cmd;
   status_type  status;
   logic [7:0]  red, green, blue, alpha, span_len;
   logic [15:0] out_row, out_col;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= 16'd4;
         height_ff <= 16'd1;
         format_ff <= '0;
         pal_ff    <= 1'b0;
         rle_ff    <= 1'b0;
         flip_ff   <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_WIDTH:   width_ff  <= csr_wdata;
            CSR_HEIGHT:  height_ff <= csr_wdata;
            CSR_FORMAT:  format_ff <= csr_wdata[1:0];
            CSR_PALETTE: pal_ff    <= csr_wdata[0];
            CSR_RLE:     rle_ff    <= csr_wdata[0];
            CSR_FLIP:    flip_ff   <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   tpsd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_kind   (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   tpsd_datapath #(.PALETTE_DEPTH(PALETTE_DEPTH)) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .data_byte      (req_tdata[7:0]),
      .palette_index  (req_tdata[15:8]),
      .palette_color  (req_tdata[39:16]),
      .image_width    (width_ff),
      .image_height   (height_ff),
      .pixel_format   (format_ff),
      .use_palette    (pal_ff),
      .rle_mode       (rle_ff),
      .bottom_up      (flip_ff),
      .red            (red),
      .green          (green),
      .blue           (blue),
      .alpha          (alpha),
      .out_row        (out_row),
      .out_col        (out_col),
      .span_len       (span_len),
      .last           (rsp_tlast),
      .frame_done     (rsp_tuser[0]),
      .overflow_error (rsp_tuser[1])
   );

   assign rsp_tdata = {span_len, out_col, out_row, alpha, blue, green, red};

endmodule

`default_nettype wire
